// ----- rtl/pvrtc_pkg.sv -----
// Shared types, constants and decode functions for the PVRTC texel decoder.
// Depends on nothing; every other file of the block imports it.
package pvrtc_pkg;

   // Operation codes of an input transaction.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TWO_BPP = 2'd0;
   localparam logic [1:0] CSR_ACROSS  = 2'd1;
   localparam logic [1:0] CSR_DOWN    = 2'd2;

   // Legal range of the size registers.
   localparam logic [3:0] LOG_MIN = 4'd1;
   localparam logic [3:0] LOG_MAX = 4'd11;

   // Modulation weight that marks a punch-through pixel.
   localparam logic [3:0] PUNCH = 4'd14;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic        operation;
      logic [11:0] block_index;
      logic [63:0] block_word;
      logic [13:0] pixel_x;
      logic [12:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rsp_type;

   // Configuration as the datapath sees it, sizes already clamped.
   typedef struct packed {
      logic       two_bpp;
      logic [3:0] across_log;
      logic [3:0] down_log;
   } cfg_type;

   // Classified transaction handed from front to back.
   typedef struct packed {
      logic        is_load;
      logic [1:0]  load_bank;
      logic [63:0] block_word;
      logic        quad_x_odd;
      logic        quad_y_odd;
      logic [2:0]  frac_x;
      logic [1:0]  frac_y;
      logic [3:0]  x_low;
      logic [2:0]  y_low;
   } item_type;

   // One colour: index 0 red, 1 green, 2 blue, 3 alpha.
   typedef logic [3:0][4:0] colour_type;
   // Index 0 is colour A, index 1 colour B.
   typedef colour_type [1:0] colour_pair_type;

   function automatic logic [3:0] plain_weight(input logic [1:0] v);
      logic [3:0] w;
      unique case (v)
         2'd0: w = 4'd0;
         2'd1: w = 4'd3;
         2'd2: w = 4'd5;
         default: w = 4'd8;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] punch_weight(input logic [1:0] v);
      logic [3:0] w;
      unique case (v)
         2'd0: w = 4'd0;
         2'd1: w = 4'd4;
         2'd2: w = PUNCH;
         default: w = 4'd8;
      endcase
      return w;
   endfunction

   // Modulation weight stored in a block for local pixel (lx, ly).
   function automatic logic [3:0] stored_mod(input logic [63:0] word, input logic two_bpp,
                                             input logic [2:0] lx, input logic [1:0] ly);
      logic [31:0] w;
      logic        mode;
      logic [3:0]  k;
      logic [1:0]  v;
      logic [3:0]  res;
      w = word[31:0];
      mode = word[32];
      k = {ly, lx[2:1]};
      v = 2'd0;
      if (!two_bpp) begin
         v = w[{ly, lx[1:0], 1'b0} +: 2];
         res = mode ? punch_weight(v) : plain_weight(v);
      end else if (!mode) begin
         res = w[{ly, lx}] ? 4'd8 : 4'd0;
      end else begin
         v = w[{k, 1'b0} +: 2];
         // The first entry and, when flagged, entry ten carry only their high bit.
         if (k == 4'd0) begin
            v = w[1] ? 2'd3 : 2'd0;
         end else if (k == 4'd10 && w[0]) begin
            v = w[21] ? 2'd3 : 2'd0;
         end
         res = plain_weight(v);
      end
      return res;
   endfunction

   // Expands the colour word of a block into colours A and B.
   function automatic colour_pair_type colours(input logic [31:0] cw);
      logic [15:0]     a;
      logic [15:0]     b;
      colour_pair_type c;
      a = cw[15:0];
      b = cw[31:16];
      if (b[15]) begin
         c[1][0] = b[14:10];
         c[1][1] = b[9:5];
         c[1][2] = b[4:0];
         c[1][3] = 5'd15;
      end else begin
         c[1][0] = {b[11:8], b[11]};
         c[1][1] = {b[7:4], b[7]};
         c[1][2] = {b[3:0], b[3]};
         c[1][3] = {1'b0, b[14:12], 1'b0};
      end
      if (a[15]) begin
         c[0][0] = a[14:10];
         c[0][1] = a[9:5];
         c[0][2] = {a[4:1], a[4]};
         c[0][3] = 5'd15;
      end else begin
         c[0][0] = {a[11:8], a[11]};
         c[0][1] = {a[7:4], a[7]};
         c[0][2] = {a[3:1], a[3:2]};
         c[0][3] = {1'b0, a[14:12], 1'b0};
      end
      return c;
   endfunction

   // Morton address of block (bx, by); coordinates already masked to the texture.
   function automatic logic [21:0] morton(input logic [10:0] bx, input logic [10:0] by,
                                          input logic [3:0] la, input logic [3:0] ld);
      logic [3:0]  least;
      logic [10:0] rest;
      logic [21:0] addr;
      int          s;
      least = (la < ld) ? la : ld;
      rest = (la < ld) ? by : bx;
      addr = '0;
      for (s = 0; s < 11; s++) begin
         if (s < int'(least)) begin
            addr[2 * s] = by[s];
            addr[2 * s + 1] = bx[s];
         end
      end
      addr = addr | ({11'd0, rest >> least} << {least, 1'b0});
      return addr;
   endfunction

endpackage

// ----- rtl/pvrtc_front.sv -----
// Front end: configuration registers and classification of input transactions.
// Computes the quad of blocks, filter fractions and per-bank addresses. Uses pvrtc_pkg.
module pvrtc_front
   import pvrtc_pkg::*;
#(
   parameter int STORE_BLOCKS_LOG2 = 12,
   parameter int AW = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [3:0]           csr_wdata,
   input  req_type              req_payload,
   output cfg_type              cfg,
   output item_type             item,
   output logic [3:0][AW-1:0]   addr
);

   localparam logic [21:0] STORE_MASK = 22'((23'd1 << STORE_BLOCKS_LOG2) - 23'd1);

   logic       two_bpp_ff, two_bpp_in;
   logic [3:0] across_ff, across_in;
   logic [3:0] down_ff, down_in;

   logic [3:0]  la, ld;
   logic [13:0] wd_mask, x, ax;
   logic [12:0] ht_mask, y, ay;
   logic [10:0] bx0, bx1, by0, by1, nbx_mask, nby_mask;
   logic [21:0] load_addr;
   logic [3:0][10:0] sel_x, sel_y;

   assign csr_ready = 1'b1;

   // Register writes.
   always_comb begin
      two_bpp_in = two_bpp_ff;
      across_in = across_ff;
      down_in = down_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TWO_BPP: two_bpp_in = csr_wdata[0];
            CSR_ACROSS:  across_in = csr_wdata;
            CSR_DOWN:    down_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         two_bpp_ff <= 1'b0;
         across_ff <= 4'd1;
         down_ff <= 4'd1;
      end else begin
         two_bpp_ff <= two_bpp_in;
         across_ff <= across_in;
         down_ff <= down_in;
      end
   end

   // Clamp the size registers into their legal range.
   always_comb begin
      la = (across_ff < LOG_MIN) ? LOG_MIN : ((across_ff > LOG_MAX) ? LOG_MAX : across_ff);
      ld = (down_ff < LOG_MIN) ? LOG_MIN : ((down_ff > LOG_MAX) ? LOG_MAX : down_ff);
      cfg = '{two_bpp: two_bpp_ff, across_log: la, down_log: ld};
   end

   // Texture coordinates, filter origin and the 2x2 block quad.
   always_comb begin
      wd_mask = 14'((15'd1 << (la + (two_bpp_ff ? 4'd3 : 4'd2))) - 15'd1);
      ht_mask = 13'((14'd1 << (ld + 4'd2)) - 14'd1);
      nbx_mask = 11'((12'd1 << la) - 12'd1);
      nby_mask = 11'((12'd1 << ld) - 12'd1);
      x = req_payload.pixel_x & wd_mask;
      y = req_payload.pixel_y & ht_mask;
      ax = (x - (two_bpp_ff ? 14'd4 : 14'd2)) & wd_mask;
      ay = (y - 13'd2) & ht_mask;
      bx0 = two_bpp_ff ? 11'(ax >> 3) : 11'(ax >> 2);
      by0 = 11'(ay >> 2);
      bx1 = (bx0 + 11'd1) & nbx_mask;
      by1 = (by0 + 11'd1) & nby_mask;
   end

   // Each bank serves the quad block whose coordinate parities match it.
   always_comb begin
      load_addr = (22'(req_payload.block_index) & STORE_MASK) >> 2;
      for (int b = 0; b < 4; b++) begin
         sel_x[b] = (bx0[0] == b[1]) ? bx0 : bx1;
         sel_y[b] = (by0[0] == b[0]) ? by0 : by1;
         if (req_payload.operation == OP_LOAD) begin
            addr[b] = AW'(load_addr);
         end else begin
            addr[b] = AW'((morton(sel_x[b], sel_y[b], la, ld) & STORE_MASK) >> 2);
         end
      end
   end

   always_comb begin
      item.is_load = (req_payload.operation == OP_LOAD);
      item.load_bank = req_payload.block_index[1:0];
      item.block_word = req_payload.block_word;
      item.quad_x_odd = bx0[0];
      item.quad_y_odd = by0[0];
      item.frac_x = two_bpp_ff ? ax[2:0] : {1'b0, ax[1:0]};
      item.frac_y = ay[1:0];
      item.x_low = x[3:0];
      item.y_low = y[2:0];
   end

endmodule

// ----- rtl/pvrtc_queue.sv -----
// Short FIFO between the front end and the back end.
// Uses pvrtc_pkg for its depth.
module pvrtc_queue
   import pvrtc_pkg::*;
#(
   parameter int WIDTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   logic [WIDTH-1:0]       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");
   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not shrink on pop");
`endif

endmodule

// ----- rtl/pvrtc_back.sv -----
// Back end: four Morton-parity block banks, modulation and bilinear colour pipeline.
// Stages: bank read, decode, filter, blend into the result register. Uses pvrtc_pkg.
module pvrtc_back
   import pvrtc_pkg::*;
#(
   parameter int AW = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               head_valid,
   input  item_type           head_item,
   input  logic [3:0][AW-1:0] head_addr,
   output logic               pop,
   output logic               rsp_valid,
   output rsp_type            rsp_payload,
   input  logic               rsp_stall
);

   localparam int BANK_DEPTH = 1 << AW;

   logic adv;
   logic [3:0][63:0] rd_word;

   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff;

   logic                       s2_valid_ff, s2_valid_in;
   logic [3:0][5:0]            s2_wt_ff, s2_wt_in;
   colour_pair_type [3:0]      s2_col_ff, s2_col_in;
   logic [3:0]                 s2_mod_ff, s2_mod_in;

   logic                  s3_valid_ff, s3_valid_in;
   logic [1:0][3:0][7:0]  s3_c_ff, s3_c_in;
   logic [3:0]            s3_mod_ff;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   // Whole pipeline moves when the result register can take new data.
   assign adv = !out_valid_ff || !rsp_stall;
   assign pop = adv && head_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   // One bank per Morton parity; a load writes one bank, a sample reads all four.
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [63:0] bank_mem [BANK_DEPTH];
      logic [63:0] rd_ff;
      always_ff @(posedge clock) begin
         if (pop && head_item.is_load && head_item.load_bank == 2'(b)) begin
            bank_mem[head_addr[b]] <= head_item.block_word;
         end
         if (pop && !head_item.is_load) begin
            rd_ff <= bank_mem[head_addr[b]];
         end
      end
      assign rd_word[b] = rd_ff;
   end

   assign s1_valid_in = pop && !head_item.is_load;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= head_item;
      end
   end

   // Decode stage: colours of the quad, filter weights and modulation weight.
   logic [4:0][3:0] tap_x;
   logic [4:0][2:0] tap_y;
   logic [4:0][3:0] tap_w;
   logic [1:0]      tap_bank;
   logic [3:0]      wx0, wx1;
   logic [2:0]      wy0, wy1;
   logic [1:0]      pix_bank;
   logic [63:0]     pix_word;
   logic [5:0]      sum4;
   logic [4:0]      sum_ud, sum_lr;

   always_comb begin
      // Quad order: top-left, top-right, bottom-left, bottom-right.
      s2_col_in[0] = colours(rd_word[{s1_item_ff.quad_x_odd, s1_item_ff.quad_y_odd}][63:32]);
      s2_col_in[1] = colours(rd_word[{!s1_item_ff.quad_x_odd, s1_item_ff.quad_y_odd}][63:32]);
      s2_col_in[2] = colours(rd_word[{s1_item_ff.quad_x_odd, !s1_item_ff.quad_y_odd}][63:32]);
      s2_col_in[3] = colours(rd_word[{!s1_item_ff.quad_x_odd, !s1_item_ff.quad_y_odd}][63:32]);

      wx0 = (cfg.two_bpp ? 4'd8 : 4'd4) - {1'b0, s1_item_ff.frac_x};
      wx1 = {1'b0, s1_item_ff.frac_x};
      wy0 = 3'd4 - {1'b0, s1_item_ff.frac_y};
      wy1 = {1'b0, s1_item_ff.frac_y};
      s2_wt_in[0] = 6'(wx0 * wy0);
      s2_wt_in[1] = 6'(wx1 * wy0);
      s2_wt_in[2] = 6'(wx0 * wy1);
      s2_wt_in[3] = 6'(wx1 * wy1);

      // Pixel and its four neighbors, all inside the quad.
      tap_x[0] = s1_item_ff.x_low;
      tap_y[0] = s1_item_ff.y_low;
      tap_x[1] = s1_item_ff.x_low - 4'd1;
      tap_y[1] = s1_item_ff.y_low;
      tap_x[2] = s1_item_ff.x_low + 4'd1;
      tap_y[2] = s1_item_ff.y_low;
      tap_x[3] = s1_item_ff.x_low;
      tap_y[3] = s1_item_ff.y_low - 3'd1;
      tap_x[4] = s1_item_ff.x_low;
      tap_y[4] = s1_item_ff.y_low + 3'd1;
      tap_bank = '0;
      for (int t = 0; t < 5; t++) begin
         tap_bank = {cfg.two_bpp ? tap_x[t][3] : tap_x[t][2], tap_y[t][2]};
         tap_w[t] = stored_mod(rd_word[tap_bank], cfg.two_bpp,
                               cfg.two_bpp ? tap_x[t][2:0] : {1'b0, tap_x[t][1:0]},
                               tap_y[t][1:0]);
      end

      pix_bank = {cfg.two_bpp ? s1_item_ff.x_low[3] : s1_item_ff.x_low[2],
                  s1_item_ff.y_low[2]};
      pix_word = rd_word[pix_bank];
      sum4 = 6'(tap_w[1]) + 6'(tap_w[2]) + 6'(tap_w[3]) + 6'(tap_w[4]) + 6'd2;
      sum_ud = 5'(tap_w[3]) + 5'(tap_w[4]) + 5'd1;
      sum_lr = 5'(tap_w[1]) + 5'(tap_w[2]) + 5'd1;
      // Interpolated 2bpp pixels off the stored checkerboard average their neighbors.
      if (!cfg.two_bpp || !(s1_item_ff.x_low[0] ^ s1_item_ff.y_low[0]) || !pix_word[32]) begin
         s2_mod_in = tap_w[0];
      end else if (!pix_word[0]) begin
         s2_mod_in = 4'(sum4 >> 2);
      end else if (pix_word[20]) begin
         s2_mod_in = 4'(sum_ud >> 1);
      end else begin
         s2_mod_in = 4'(sum_lr >> 1);
      end
   end

   assign s2_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_wt_ff <= s2_wt_in;
         s2_col_ff <= s2_col_in;
         s2_mod_ff <= s2_mod_in;
      end
   end

   // Filter stage: bilinear sum per colour and channel, scaled to eight bits.
   logic [12:0] v;

   always_comb begin
      v = '0;
      for (int i = 0; i < 2; i++) begin
         for (int k = 0; k < 4; k++) begin
            v = 13'(s2_col_ff[0][i][k] * s2_wt_ff[0]) + 13'(s2_col_ff[1][i][k] * s2_wt_ff[1])
              + 13'(s2_col_ff[2][i][k] * s2_wt_ff[2]) + 13'(s2_col_ff[3][i][k] * s2_wt_ff[3]);
            if (k == 3) begin
               s3_c_in[i][k] = cfg.two_bpp ? 8'((v >> 5) + (v >> 1)) : 8'((v >> 4) + v);
            end else begin
               s3_c_in[i][k] = cfg.two_bpp ? 8'((v >> 7) + (v >> 2)) : 8'((v >> 6) + (v >> 1));
            end
         end
      end
   end

   assign s3_valid_in = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_c_ff <= s3_c_in;
         s3_mod_ff <= s2_mod_ff;
      end
   end

   // Blend stage: mix colours A and B by weight; punch-through averages them with zero alpha.
   logic [3:0][7:0] res;
   logic [11:0]     mix;

   always_comb begin
      mix = '0;
      for (int k = 0; k < 4; k++) begin
         if (s3_mod_ff == PUNCH) begin
            mix = (12'(s3_c_ff[0][k]) + 12'(s3_c_ff[1][k])) >> 1;
            res[k] = (k == 3) ? 8'd0 : 8'(mix);
         end else begin
            mix = 12'(s3_c_ff[0][k] * (4'd8 - s3_mod_ff)) + 12'(s3_c_ff[1][k] * s3_mod_ff);
            res[k] = 8'(mix >> 3);
         end
      end
      out_in = '{red: res[0], green: res[1], blue: res[2], alpha: res[3]};
   end

   assign out_valid_in = s3_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      pop && head_item.is_load |=> !s1_valid_ff)
      else $error("load transaction entered the sample pipeline");
   assert property (@(posedge clock) disable iff (reset)
      adv && s3_valid_ff |=> out_valid_ff)
      else $error("filtered sample lost before the result register");
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !adv |=> s2_valid_ff && $stable(s2_mod_ff))
      else $error("decode stage changed while the pipeline was held");
`endif

endmodule

// ----- rtl/pvrtc_texel_decoder_unit.sv -----
// A sample passes the queue, then the bank read, decode, filter and result registers.
// Throughput: one transaction per cycle while the queue is not full and rsp_stall is low;
// each of the four Morton-parity banks serves one 2x2-quad block per cycle. A load takes one
// queue slot and gives no result. Reset (synchronous) clears queue, pipeline valids and
// registers; block store content is undefined until loaded and needs no clearing pass.
module pvrtc_texel_decoder_unit
   import pvrtc_pkg::*;
#(
   parameter int STORE_BLOCKS_LOG2 = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_wdata
);

   localparam int AW = (STORE_BLOCKS_LOG2 > 2) ? STORE_BLOCKS_LOG2 - 2 : 1;
   localparam int QW = $bits(item_type) + 4 * AW;

   cfg_type            cfg;
   item_type           front_item, head_item;
   logic [3:0][AW-1:0] front_addr, head_addr;
   logic               push, pop, full, not_empty;

   assign req_stall = full;
   assign push = req_valid && !full;

   // Front end classifies each transaction.
   pvrtc_front #(
      .STORE_BLOCKS_LOG2(STORE_BLOCKS_LOG2),
      .AW(AW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_payload(req_payload),
      .cfg(cfg),
      .item(front_item),
      .addr(front_addr)
   );

   // Queue decouples front and back.
   pvrtc_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data({front_item, front_addr}),
      .full(full),
      .pop(pop),
      .pop_data({head_item, head_addr}),
      .not_empty(not_empty)
   );

   // Back end executes loads and samples.
   pvrtc_back #(
      .AW(AW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .head_valid(not_empty),
      .head_item(head_item),
      .head_addr(head_addr),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .rsp_stall(rsp_stall)
   );

endmodule
